>>> sv/clgc_pkg.sv
// ----------------------------------------------------------------------------
// Coleman-Liau grade counter package
// Shared beat types, sequencer states and fixed constants of the index formula.
// ----------------------------------------------------------------------------
package clgc_pkg;

  // One beat of text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  // One report beat, sent after the last byte of a text.
  typedef struct packed {
    logic [15:0]       letter_total;
    logic [15:0]       word_total;
    logic [15:0]       sentence_total;
    logic signed [7:0] raw_index;
    logic [4:0]        grade;
  } report_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB_S,
    ST_SUB_W,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  // Index weights, each scaled by 100 (DEN_WEIGHT scales the word count of the divisor).
  localparam int LETTER_WEIGHT   = 588;
  localparam int SENTENCE_WEIGHT = 2960;
  localparam int WORD_WEIGHT     = 1580;
  localparam int DEN_WEIGHT      = 100;

  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_PERIOD   = 8'h2E;
  localparam logic [7:0] CH_EXCLAIM  = 8'h21;
  localparam logic [7:0] CH_QUESTION = 8'h3F;

  // The divider produces quotient bits from this position down to zero.
  localparam logic [3:0] STEP_FIRST = 4'd8;

  localparam logic signed [7:0] INDEX_MAX = 8'sd127;
  localparam logic signed [7:0] INDEX_MIN = -8'sd128;
  localparam logic signed [7:0] GRADE_TOP = 8'sd16;
  localparam logic [4:0]        GRADE_OVER = 5'd17;

endpackage

>>> sv/coleman_liau_grade_counter_top.sv
// ----------------------------------------------------------------------------
// Coleman-Liau grade counter
// Counts letters, words and sentences of a byte stream and reports the
// rounded Coleman-Liau index and grade code after the last byte.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while counting.
// After the beat marked last, the block is busy and text_ready is low: the weight
// multiplies, the subtractions forming the numerator, one sign and rounding prep,
// nine steps of a shared restoring subtractor, and a final state that forms the report.
// report_valid rises when the final state loads a free report register.
// Reset (rst, synchronous): counters to 0 letters, 1 word, 0 sentences; idle.
module coleman_liau_grade_counter_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  clgc_pkg::text_beat_t  text,
  output logic                  report_valid,
  input  logic                  report_ready,
  output clgc_pkg::report_beat_t report
);

  // The widest numerator term is 2960 times a full counter, under 2^(CW+12).
  // NW holds the signed numerator; DW holds the divisor shifted up by eight.
  localparam int CW = COUNT_WIDTH;
  localparam int NW = CW + 14;
  localparam int DW = CW + 16;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  // Streaming counters.
  logic [CW-1:0] letter_count, letter_count_next;
  logic [CW-1:0] word_count, word_count_next;
  logic [CW-1:0] sentence_count, sentence_count_next;

  // Operands captured at the end of a text.
  logic [CW-1:0] op_l, op_w, op_s;

  // Arithmetic working registers.
  logic [NW-1:0] prod_l, prod_s, prod_w, den;
  logic [NW-1:0] num;
  logic [NW-1:0] mag;
  logic [DW-1:0] rem, dvs, dvs_shift;
  logic [DW:0]   trial;
  logic [8:0]    quot;
  logic [3:0]    step;
  logic          neg;

  clgc_pkg::state_t state, state_next;

  logic accept_text;
  logic is_letter, is_space, is_mark;
  logic load_report;
  logic q_sat;
  logic signed [7:0] index_val;
  logic [4:0]        grade_val;

  assign accept_text = text_valid && text_ready;

  // Byte classification. Bytes above 127 fall in none of the classes.
  assign is_letter = ((text.ch >= 8'h41) && (text.ch <= 8'h5A)) ||
                     ((text.ch >= 8'h61) && (text.ch <= 8'h7A));
  assign is_space  = (text.ch == clgc_pkg::CH_SPACE);
  assign is_mark   = (text.ch == clgc_pkg::CH_PERIOD) ||
                     (text.ch == clgc_pkg::CH_EXCLAIM) ||
                     (text.ch == clgc_pkg::CH_QUESTION);

  // Each counter saturates at its all-ones value.
  always_comb begin
    letter_count_next   = letter_count;
    word_count_next     = word_count;
    sentence_count_next = sentence_count;
    if (is_letter && (letter_count != COUNT_MAX)) begin
      letter_count_next = letter_count + 1'b1;
    end
    if (is_space && (word_count != COUNT_MAX)) begin
      word_count_next = word_count + 1'b1;
    end
    if (is_mark && (sentence_count != COUNT_MAX)) begin
      sentence_count_next = sentence_count + 1'b1;
    end
  end

  // Sequencer. Counting happens in idle; everything after is one pass of
  // the index computation. The report register decouples the output side,
  // so a new text can stream in while an old report waits to be taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clgc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    text_ready  = 1'b0;
    load_report = 1'b0;
    unique case (state)
      clgc_pkg::ST_IDLE: begin
        text_ready = 1'b1;
        if (text_valid && text.last) begin
          state_next = clgc_pkg::ST_MUL;
        end
      end
      clgc_pkg::ST_MUL:   state_next = clgc_pkg::ST_SUB_S;
      clgc_pkg::ST_SUB_S: state_next = clgc_pkg::ST_SUB_W;
      clgc_pkg::ST_SUB_W: state_next = clgc_pkg::ST_PREP;
      clgc_pkg::ST_PREP:  state_next = clgc_pkg::ST_DIV;
      clgc_pkg::ST_DIV: begin
        if (step == '0) begin
          state_next = clgc_pkg::ST_DONE;
        end
      end
      clgc_pkg::ST_DONE: begin
        // Hold the finished index until the report register is free.
        if (!report_valid || report_ready) begin
          load_report = 1'b1;
          state_next  = clgc_pkg::ST_IDLE;
        end
      end
      default: state_next = clgc_pkg::ST_IDLE;
    endcase
  end

  // Counters: the last byte is counted into the captured operands, and the
  // live counters return to their reset values in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_count   <= '0;
      word_count     <= CW'(1);
      sentence_count <= '0;
    end else if (accept_text) begin
      if (text.last) begin
        letter_count   <= '0;
        word_count     <= CW'(1);
        sentence_count <= '0;
      end else begin
        letter_count   <= letter_count_next;
        word_count     <= word_count_next;
        sentence_count <= sentence_count_next;
      end
    end
  end

  // Divider trial subtraction: the one shared shift and subtract unit.
  assign dvs_shift = dvs << step;
  assign trial     = {1'b0, rem} - {1'b0, dvs_shift};
  assign mag       = num[NW-1] ? (~num + 1'b1) : num;

  // Index datapath. The numerator is 588L - 2960S - 1580W and the rounded
  // magnitude is floor((2|num| + 100W) / (200W)), rounding half away from 0.
  always_ff @(posedge clk) begin
    if (accept_text && text.last) begin
      op_l <= letter_count_next;
      op_w <= word_count_next;
      op_s <= sentence_count_next;
    end
    unique case (state)
      clgc_pkg::ST_MUL: begin
        prod_l <= NW'(op_l) * NW'(clgc_pkg::LETTER_WEIGHT);
        prod_s <= NW'(op_s) * NW'(clgc_pkg::SENTENCE_WEIGHT);
        prod_w <= NW'(op_w) * NW'(clgc_pkg::WORD_WEIGHT);
        den    <= NW'(op_w) * NW'(clgc_pkg::DEN_WEIGHT);
      end
      clgc_pkg::ST_SUB_S: num <= prod_l - prod_s;
      clgc_pkg::ST_SUB_W: num <= num - prod_w;
      clgc_pkg::ST_PREP: begin
        neg  <= num[NW-1];
        rem  <= DW'({mag, 1'b0}) + DW'(den);
        dvs  <= DW'({den, 1'b0});
        quot <= '0;
        step <= clgc_pkg::STEP_FIRST;
      end
      clgc_pkg::ST_DIV: begin
        // A set top bit means the quotient is at least 256; the later bits
        // then no longer matter because the index saturates.
        if (!trial[DW]) begin
          rem        <= trial[DW-1:0];
          quot[step] <= 1'b1;
        end
        if (step != '0) begin
          step <= step - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Saturate the signed index and map it to a grade code.
  always_comb begin
    q_sat = quot[8] || quot[7];
    if (neg) begin
      index_val = q_sat ? clgc_pkg::INDEX_MIN : -$signed({1'b0, quot[6:0]});
    end else begin
      index_val = q_sat ? clgc_pkg::INDEX_MAX : $signed({1'b0, quot[6:0]});
    end
    if (index_val < 8'sd1) begin
      grade_val = '0;
    end else if (index_val <= clgc_pkg::GRADE_TOP) begin
      grade_val = index_val[4:0];
    end else begin
      grade_val = clgc_pkg::GRADE_OVER;
    end
  end

  // Report register.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (load_report) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_report) begin
      report.letter_total   <= 16'(op_l);
      report.word_total     <= 16'(op_w);
      report.sentence_total <= 16'(op_s);
      report.raw_index      <= index_val;
      report.grade          <= grade_val;
    end
  end

  // A last beat always leaves the live counters at their reset values.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept_text && text.last) |=>
      (letter_count == '0 && word_count == CW'(1) && sentence_count == '0))
    else $error("counters not cleared after last beat");

  // The word counter starts at one and never wraps back to zero.
  a_words_nonzero: assert property (@(posedge clk) disable iff (rst)
    word_count != '0)
    else $error("word counter reached zero");

  // Grade code agrees with the reported index.
  a_grade_match: assert property (@(posedge clk) disable iff (rst)
    (report_valid && report.raw_index >= 8'sd1 && report.raw_index <= 8'sd16)
      |-> (report.grade == report.raw_index[4:0]))
    else $error("grade does not match index");

  // The divider step never starts above the top quotient bit.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == clgc_pkg::ST_DIV) |-> (step <= clgc_pkg::STEP_FIRST))
    else $error("divider step out of range");

endmodule
